### design/adsp_pkg.sv
`timescale 1ns / 1ps
package adsp_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t K_WS  = 2'd0;
    localparam kind_t K_LIT = 2'd1;
    localparam kind_t K_INT = 2'd2;
    localparam kind_t K_STR = 2'd3;

    localparam int NPAT = 3;
    localparam int NDIR = 11;
    localparam int NMON = 12;
    localparam logic [6:0] YEAR_ADJ = 7'd48;

    localparam logic [1:0] FMT_DEFAULT = 2'd0;
    localparam logic [1:0] FMT_NAMED   = 2'd1;
    localparam logic [1:0] FMT_WORD    = 2'd2;
    localparam logic [1:0] FMT_SLASH   = 2'd3;

    localparam kind_t DIR_KIND [0:2][0:10] = '{
        '{K_INT, K_WS, K_STR, K_WS, K_INT, K_WS, K_INT, K_LIT, K_INT, K_LIT, K_INT},
        '{K_STR, K_WS, K_INT, K_WS, K_STR, K_WS, K_INT, K_WS, K_INT, K_LIT, K_INT},
        '{K_INT, K_LIT, K_INT, K_LIT, K_INT, K_WS, K_INT, K_LIT, K_INT, K_LIT, K_INT}};

    localparam logic [7:0] DIR_ARG [0:2][0:10] = '{
        '{8'd0, 8'd0, 8'd1, 8'd0, 8'd2, 8'd0, 8'd3, 8'h3A, 8'd4, 8'h3A, 8'd5},
        '{8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd2, 8'd0, 8'd3, 8'h3A, 8'd4},
        '{8'd1, 8'h2F, 8'd0, 8'h2F, 8'd2, 8'd0, 8'd3, 8'h3A, 8'd4, 8'h3A, 8'd5}};

    localparam logic [3:0] DIR_LEN [0:2] = '{4'd11, 4'd10, 4'd11};

    localparam logic [7:0] MONTH_TXT [0:35] = '{
        "j","a","n","f","e","b","m","a","r","a","p","r","m","a","y","j","u","n",
        "j","u","l","a","u","g","s","e","p","o","c","t","n","o","v","d","e","c"};

    typedef struct packed {
        logic [7:0] code;
        logic [7:0] lower;
        logic       blank;
        logic       digit;
        logic [3:0] dval;
        logic       term;
    } cls_t;

    typedef struct packed {
        logic [3:0]      pos;
        logic [6:0]      acc;
        logic            f_sign;
        logic            f_seen;
        logic            f_neg;
        logic [2:0]      cnt;
        logic            dead;
        logic [5:0][6:0] caps;
        logic [11:0]     mmask;
        logic [1:0]      mlen;
    } pat_t;

    function automatic pat_t pat_reset();
        pat_t s;
        s = '0;
        s.mmask = 12'hFFF;
        return s;
    endfunction

    function automatic pat_t store_num(input pat_t s, input logic [7:0] arg);
        pat_t n;
        n = s;
        n.caps[arg[2:0]] = s.f_neg ? 7'(7'd0 - s.acc) : s.acc;
        n.cnt = s.cnt + 3'd1;
        return n;
    endfunction

    function automatic pat_t step_dir(input pat_t s, input logic [1:0] p, input cls_t c);
        pat_t n;
        kind_t kind;
        logic [7:0] arg;
        logic [10:0] prod;
        n = s;
        kind = DIR_KIND[p][s.pos];
        arg = DIR_ARG[p][s.pos];
        prod = {1'b0, s.acc, 3'b0} + {3'b0, s.acc, 1'b0} + {7'd0, c.dval};
        if (!s.dead && s.pos < DIR_LEN[p])
        begin
            case (kind)
                K_WS:
                begin
                    if (!c.blank)
                        n.pos = s.pos + 4'd1;
                end
                K_LIT:
                begin
                    if (c.code == arg)
                        n.pos = s.pos + 4'd1;
                    else
                        n.dead = 1'b1;
                end
                K_INT:
                begin
                    if (c.digit)
                    begin
                        n.acc = prod[6:0];
                        n.f_seen = 1'b1;
                    end
                    else if (!s.f_sign && !s.f_seen && !s.f_neg)
                    begin
                        if (c.code == "+" || c.code == "-")
                        begin
                            n.f_sign = 1'b1;
                            n.f_neg = (c.code == "-");
                        end
                        else if (!c.blank)
                            n.dead = 1'b1;
                    end
                    else if (!s.f_seen)
                        n.dead = 1'b1;
                    else
                    begin
                        n = store_num(s, arg);
                        n.acc = '0;
                        n.f_sign = 1'b0;
                        n.f_seen = 1'b0;
                        n.f_neg = 1'b0;
                        n.pos = s.pos + 4'd1;
                    end
                end
                default:
                begin
                    if (!c.blank)
                    begin
                        n.f_sign = 1'b0;
                        n.f_neg = 1'b0;
                        n.f_seen = 1'b1;
                        if (arg != 8'd0)
                        begin
                            if (s.mlen == 2'd3)
                                n.mmask = '0;
                            else
                            begin
                                for (int m = 0; m < NMON; m++)
                                    if (MONTH_TXT[m * 3 + int'(s.mlen)] != c.lower)
                                        n.mmask[m] = 1'b0;
                                n.mlen = s.mlen + 2'd1;
                            end
                        end
                    end
                    else if (s.f_seen)
                    begin
                        if (arg != 8'd0)
                            n.cnt = s.cnt + 3'd1;
                        n.f_sign = 1'b0;
                        n.f_seen = 1'b0;
                        n.f_neg = 1'b0;
                        n.pos = s.pos + 4'd1;
                    end
                end
            endcase
        end
        return n;
    endfunction

    function automatic pat_t pat_char(input pat_t s, input logic [1:0] p, input cls_t c);
        pat_t cur;
        pat_t n;
        logic go;
        cur = s;
        go = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (go)
            begin
                n = step_dir(cur, p, c);
                go = (n.pos != cur.pos) && (DIR_KIND[p][cur.pos] != K_LIT);
                cur = n;
            end
        end
        return cur;
    endfunction

    function automatic pat_t pat_finish(input pat_t s, input logic [1:0] p);
        pat_t n;
        n = s;
        if (!s.dead && s.pos < DIR_LEN[p] && s.f_seen)
        begin
            if (DIR_KIND[p][s.pos] == K_INT)
                n = store_num(s, DIR_ARG[p][s.pos]);
            else if (DIR_KIND[p][s.pos] == K_STR && DIR_ARG[p][s.pos] != 8'd0)
                n.cnt = s.cnt + 3'd1;
        end
        return n;
    endfunction

    function automatic logic [6:0] month_of(input pat_t s);
        logic [6:0] r;
        logic hit;
        r = 7'd1;
        hit = 1'b0;
        if (s.mlen == 2'd3)
        begin
            for (int m = 0; m < NMON; m++)
            begin
                if (!hit && s.mmask[m])
                begin
                    r = 7'(m + 1);
                    hit = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

### design/adsp_front.sv
`timescale 1ns / 1ps
module adsp_front (
    input  logic [7:0]    char_code,
    output adsp_pkg::cls_t cls
);
    import adsp_pkg::*;

    always_comb
    begin
        cls.code  = char_code;
        cls.lower = (char_code >= "A" && char_code <= "Z") ? (char_code | 8'h20) : char_code;
        cls.blank = (char_code == 8'd32) || (char_code >= 8'd9 && char_code <= 8'd13);
        cls.digit = (char_code >= "0" && char_code <= "9");
        cls.dval  = cls.digit ? 4'(char_code - "0") : 4'd0;
        cls.term  = (char_code == 8'd0);
    end
endmodule

### design/adsp_queue.sv
`timescale 1ns / 1ps
module adsp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  adsp_pkg::cls_t wdata,
    output logic           full,
    input  logic           rd,
    output adsp_pkg::cls_t rdata,
    output logic           empty
);
    import adsp_pkg::*;

    cls_t       mem_reg [0:1];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = mem_reg[rptr_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= !wptr_reg;
            if (do_rd)
                rptr_reg <= !rptr_reg;
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end
endmodule

### design/adsp_back.sv
`timescale 1ns / 1ps
module adsp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  adsp_pkg::cls_t cls,
    input  logic           q_empty,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output logic [4:0]     day,
    output logic [3:0]     month,
    output logic [6:0]     year_since_1980,
    output logic [4:0]     hour,
    output logic [5:0]     minute,
    output logic [4:0]     half_seconds,
    output logic [1:0]     format_used
);
    import adsp_pkg::*;

    pat_t       pat_reg  [0:2];
    pat_t       pat_next [0:2];
    pat_t       fin      [0:2];
    logic       res_valid_reg;
    logic [4:0] day_reg;
    logic [3:0] month_reg;
    logic [6:0] year_reg;
    logic [4:0] hour_reg;
    logic [5:0] minute_reg;
    logic [4:0] half_reg;
    logic [1:0] fmt_reg;
    logic [6:0] da, mo, yr, hh, mi, ss;
    logic [1:0] fmt;
    logic       res_take;

    assign res_take = pop && res_valid_reg;
    assign q_pop = !q_empty && (!cls.term || !res_valid_reg || res_take);
    assign empty = !res_valid_reg;
    assign day = day_reg;
    assign month = month_reg;
    assign year_since_1980 = year_reg;
    assign hour = hour_reg;
    assign minute = minute_reg;
    assign half_seconds = half_reg;
    assign format_used = fmt_reg;

    always_comb
    begin
        for (int p = 0; p < NPAT; p++)
        begin
            fin[p] = pat_finish(pat_reg[p], 2'(p));
            if (q_pop && cls.term)
                pat_next[p] = pat_reset();
            else if (q_pop)
                pat_next[p] = pat_char(pat_reg[p], 2'(p), cls);
            else
                pat_next[p] = pat_reg[p];
        end
        da = 7'd1; mo = 7'd1; yr = 7'd80; hh = '0; mi = '0; ss = '0;
        fmt = FMT_DEFAULT;
        if (fin[0].cnt >= 3'd5)
        begin
            fmt = FMT_NAMED;
            mo = month_of(fin[0]);
            if (fin[0].cnt >= 3'd6)
                ss = fin[0].caps[5];
            da = fin[0].caps[0]; yr = fin[0].caps[2];
            hh = fin[0].caps[3]; mi = fin[0].caps[4];
        end
        else if (fin[1].cnt == 3'd5)
        begin
            fmt = FMT_WORD;
            mo = month_of(fin[1]);
            da = fin[1].caps[0]; yr = fin[1].caps[2];
            hh = fin[1].caps[3]; mi = fin[1].caps[4];
        end
        else if (fin[2].cnt == 3'd6)
        begin
            fmt = FMT_SLASH;
            mo = fin[2].caps[1];
            ss = fin[2].caps[5];
            da = fin[2].caps[0]; yr = fin[2].caps[2];
            hh = fin[2].caps[3]; mi = fin[2].caps[4];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && cls.term)
        begin
            day_reg    <= da[4:0];
            month_reg  <= mo[3:0];
            year_reg   <= yr + YEAR_ADJ;
            hour_reg   <= hh[4:0];
            minute_reg <= mi[5:0];
            half_reg   <= ss[5:1];
            fmt_reg    <= fmt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NPAT; p++)
                pat_reg[p] <= pat_reset();
            res_valid_reg <= 1'b0;
        end
        else
        begin
            for (int p = 0; p < NPAT; p++)
                pat_reg[p] <= pat_next[p];
            if (q_pop && cls.term)
                res_valid_reg <= 1'b1;
            else if (res_take)
                res_valid_reg <= 1'b0;
        end
    end
endmodule

### design/ascii_date_to_packed_stamp.sv
`timescale 1ns / 1ps
// Packs a text date, fed one character per beat and closed by a zero byte, into a
// 1980-based stamp. One character is taken every cycle while the input queue is not
// full; the three pattern recognizers update once per character. The zero byte is
// first written into the input queue, and the stamp is registered when the
// recognizers read that byte straight from the queue. The result register holds one
// stamp; a following string keeps flowing until its own zero byte arrives while that
// stamp is still unpopped.
module ascii_date_to_packed_stamp (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_code,
    output logic       empty,
    input  logic       pop,
    output logic [4:0] day,
    output logic [3:0] month,
    output logic [6:0] year_since_1980,
    output logic [4:0] hour,
    output logic [5:0] minute,
    output logic [4:0] half_seconds,
    output logic [1:0] format_used
);
    import adsp_pkg::*;

    cls_t cls_in;
    cls_t cls_out;
    logic q_empty;
    logic q_pop;

    adsp_front u_front (
        .char_code (char_code),
        .cls       (cls_in)
    );

    adsp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .wdata (cls_in),
        .full  (full),
        .rd    (q_pop),
        .rdata (cls_out),
        .empty (q_empty)
    );

    adsp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cls             (cls_out),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .empty           (empty),
        .pop             (pop),
        .day             (day),
        .month           (month),
        .year_since_1980 (year_since_1980),
        .hour            (hour),
        .minute          (minute),
        .half_seconds    (half_seconds),
        .format_used     (format_used)
    );
endmodule

### sim/ascii_date_to_packed_stamp_checker.sv
`timescale 1ns / 1ps
module ascii_date_to_packed_stamp_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] char_code,
    input  logic       empty,
    input  logic       pop,
    input  logic [4:0] day,
    input  logic [3:0] month,
    input  logic [6:0] year_since_1980,
    input  logic [4:0] hour,
    input  logic [5:0] minute,
    input  logic [4:0] half_seconds,
    input  logic [1:0] format_used,
    output int         errors,
    output int         pending
);
    import adsp_pkg::*;

    typedef struct packed {
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] half_sec;
        logic [1:0] fmt;
    } stamp_t;

    typedef struct {
        logic [3:0] pos;
        logic [6:0] acc;
        logic       sgn;
        logic       seen;
        logic       neg;
        logic [2:0] convs;
        logic       dead;
        logic [6:0] fld [6];
        logic [11:0] mmask;
        logic [2:0]  mlen;
    } scan_t;

    // three-letter month names, january first
    localparam string MONTHS = "janfebmaraprmayjunjulaugsepoctnovdec";

    scan_t  scan [3];
    stamp_t stamps_due [$];

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic void scan_clear(inout scan_t s);
        s.pos = '0; s.acc = '0; s.sgn = 0; s.seen = 0; s.neg = 0;
        s.convs = '0; s.dead = 0; s.mmask = 12'hFFF; s.mlen = '0;
        for (int i = 0; i < 6; i++)
            s.fld[i] = '0;
    endfunction

    function automatic void keep_number(inout scan_t s, input logic [7:0] slot);
        s.fld[slot % 6] = s.neg ? 7'(7'd0 - s.acc) : s.acc;
        s.convs++;
    endfunction

    function automatic void scan_char(inout scan_t s, input int p, input logic [7:0] c);
        kind_t k;
        logic [7:0] a;
        logic [7:0] lc;
        while (!s.dead && s.pos < DIR_LEN[p])
        begin
            k = DIR_KIND[p][s.pos];
            a = DIR_ARG[p][s.pos];
            if (k == K_WS)
            begin
                if (is_blank(c))
                    return;
                s.pos++;
            end
            else if (k == K_LIT)
            begin
                if (c == a)
                    s.pos++;
                else
                    s.dead = 1;
                return;
            end
            else if (k == K_INT)
            begin
                if (c >= "0" && c <= "9")
                begin
                    s.acc = 7'(s.acc * 10 + (c - 8'd48));
                    s.seen = 1;
                    return;
                end
                if (!s.sgn && !s.seen && !s.neg)
                begin
                    if (is_blank(c))
                        return;
                    if (c == "+" || c == "-")
                    begin
                        s.sgn = 1;
                        s.neg = (c == "-");
                    end
                    else
                        s.dead = 1;
                    return;
                end
                if (!s.seen)
                begin
                    s.dead = 1;
                    return;
                end
                keep_number(s, a);
                s.acc = '0; s.sgn = 0; s.seen = 0; s.neg = 0;
                s.pos++;
            end
            else
            begin
                if (!is_blank(c))
                begin
                    s.sgn = 0; s.neg = 0; s.seen = 1;
                    if (a != 0 && p < 2)
                    begin
                        if (s.mlen >= 3)
                            s.mmask = '0;
                        else
                        begin
                            lc = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
                            for (int m = 0; m < 12; m++)
                                if (MONTHS[m * 3 + s.mlen] != lc)
                                    s.mmask[m] = 0;
                            s.mlen++;
                        end
                    end
                    return;
                end
                if (!s.seen)
                    return;
                if (a != 0)
                    s.convs++;
                s.sgn = 0; s.seen = 0; s.neg = 0;
                s.pos++;
            end
        end
    endfunction

    function automatic logic [6:0] month_number(input scan_t s);
        if (s.mlen == 3)
            for (int m = 0; m < 12; m++)
                if (s.mmask[m])
                    return 7'(m + 1);
        return 7'd1;
    endfunction

    function automatic stamp_t close_string();
        logic [6:0] da, mo, yr, hh, mi, ss;
        int w;
        stamp_t r;
        da = 1; mo = 1; yr = 80; hh = 0; mi = 0; ss = 0; w = 3;
        r.fmt = FMT_DEFAULT;
        for (int p = 0; p < 3; p++)
            if (!scan[p].dead && scan[p].pos < DIR_LEN[p] && scan[p].seen)
            begin
                if (DIR_KIND[p][scan[p].pos] == K_INT)
                    keep_number(scan[p], DIR_ARG[p][scan[p].pos]);
                else if (DIR_KIND[p][scan[p].pos] == K_STR && DIR_ARG[p][scan[p].pos] != 0)
                    scan[p].convs++;
            end
        if (scan[0].convs >= 5)
        begin
            w = 0; r.fmt = FMT_NAMED; mo = month_number(scan[0]);
            if (scan[0].convs >= 6)
                ss = scan[0].fld[5];
        end
        else if (scan[1].convs == 5)
        begin
            w = 1; r.fmt = FMT_WORD; mo = month_number(scan[1]);
        end
        else if (scan[2].convs == 6)
        begin
            w = 2; r.fmt = FMT_SLASH; mo = scan[2].fld[1]; ss = scan[2].fld[5];
        end
        if (w < 3)
        begin
            da = scan[w].fld[0]; yr = scan[w].fld[2];
            hh = scan[w].fld[3]; mi = scan[w].fld[4];
        end
        r.day = da[4:0]; r.month = mo[3:0]; r.year = 7'(yr - 7'd80);
        r.hour = hh[4:0]; r.minute = mi[5:0]; r.half_sec = ss[5:1];
        for (int p = 0; p < 3; p++)
            scan_clear(scan[p]);
        return r;
    endfunction

    initial
    begin
        errors = 0;
        for (int p = 0; p < 3; p++)
            scan_clear(scan[p]);
    end

    assign pending = stamps_due.size();

    always @(posedge clk)
    begin
        stamp_t got, want;
        if (rst_n)
        begin
            if (push && !full)
            begin
                if (char_code != 0)
                    for (int p = 0; p < 3; p++)
                        scan_char(scan[p], p, char_code);
                else
                    stamps_due.push_back(close_string());
            end
            if (pop && !empty)
            begin
                got = '{day, month, year_since_1980, hour, minute, half_seconds, format_used};
                if (stamps_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected stamp %h at %0t", got, $realtime);
                end
                else
                begin
                    want = stamps_due.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"stamp mismatch: exp d%0d m%0d y%0d %0d:%0d s%0d f%0d,",
                                      " got d%0d m%0d y%0d %0d:%0d s%0d f%0d"},
                                want.day, want.month, want.year, want.hour, want.minute,
                                want.half_sec, want.fmt, got.day, got.month, got.year,
                                got.hour, got.minute, got.half_sec, got.fmt);
                    end
                end
            end
        end
    end
endmodule

### sim/ascii_date_to_packed_stamp_tb.sv
`timescale 1ns / 1ps
module ascii_date_to_packed_stamp_tb;
    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] char_code;
    logic       empty;
    logic       pop;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year_since_1980;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [4:0] half_seconds;
    logic [1:0] format_used;
    int         errors;
    int         pending;
    int         beats_sent;
    int         burst_left;
    logic       hold_pop;
    logic       feed_done;
    byte unsigned chars [$];

    ascii_date_to_packed_stamp i_dut (.*);

    ascii_date_to_packed_stamp_checker i_checker (.*);

    initial
    begin
        clk = 0;
    end

    always #10 clk = ~clk;

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            chars.push_back(s[i]);
        chars.push_back(8'd0);
    endtask

    function automatic string rnd_num();
        string s;
        int n;
        s = "";
        case ($urandom_range(0, 9))
            0: s = "-";
            1: s = "+";
            default: ;
        endcase
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'($urandom_range(48, 57)))};
        return s;
    endfunction

    function automatic string rnd_month();
        string names [12] = '{"Jan", "feb", "MAR", "apr", "May", "jun",
                              "Jul", "aug", "SEP", "Oct", "nov", "Dec"};
        case ($urandom_range(0, 7))
            0: return "Sept";
            1: return "xyz";
            2: return "Ja";
            default: return names[$urandom_range(0, 11)];
        endcase
    endfunction

    function automatic string rnd_gap();
        string g [4] = '{" ", "  ", "\t", " \n "};
        return g[$urandom_range(0, 3)];
    endfunction

    function automatic string mangle(input string s);
        int k;
        if (s.len() == 0)
            return s;
        k = $urandom_range(0, s.len() - 1);
        s[k] = byte'($urandom_range(1, 255));
        return s;
    endfunction

    task automatic add_random_string();
        string s;
        case ($urandom_range(0, 3))
            0: s = {rnd_num(), rnd_gap(), rnd_month(), rnd_gap(), rnd_num(), rnd_gap(),
                    rnd_num(), ":", rnd_num(), ($urandom_range(0, 2) != 0) ?
                    {":", rnd_num()} : ""};
            1: s = {"Mon", rnd_gap(), rnd_num(), rnd_gap(), rnd_month(), rnd_gap(),
                    rnd_num(), rnd_gap(), rnd_num(), ":", rnd_num()};
            2: s = {rnd_num(), "/", rnd_num(), "/", rnd_num(), rnd_gap(), rnd_num(),
                    ":", rnd_num(), ":", rnd_num()};
            default:
            begin
                s = "";
                for (int i = $urandom_range(0, 8); i > 0; i--)
                    s = {s, string'(byte'($urandom_range(1, 255)))};
            end
        endcase
        if ($urandom_range(0, 5) == 0)
            s = mangle(s);
        if ($urandom_range(0, 9) == 0)
            s = {rnd_gap(), s, " trailing"};
        add_text(s);
    endtask

    initial
    begin
        add_text("");
        add_text("31 Dec 99 23:59:58");
        add_text("1 jan 80 00:00");
        add_text("Tue 15 MAR 21 12:34");
        add_text("12/25/99 23:59:59");
        add_text("127 Sept 255 -1:+99:999");
        add_text("7 - 80 1:2");
        add_text("\xff\x80 01 Jan 80 0:0:0");
        add_text("garbage");
        while (chars.size() < 1750)
            add_random_string();
    end

    initial
    begin
        rst_n = 0;
        push = 0;
        char_code = 0;
        feed_done = 0;
        beats_sent = 0;
        burst_left = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        while (chars.size() > 0)
        begin
            if (burst_left == 0)
            begin
                push = 0;
                repeat ((beats_sent > 300 && beats_sent < 400) ? 0 : $urandom_range(0, 4))
                    @(negedge clk);
                burst_left = $urandom_range(1, 30);
            end
            push = 1;
            char_code = chars[0];
            @(posedge clk);
            if (!full)
            begin
                void'(chars.pop_front());
                beats_sent++;
                burst_left--;
            end
            @(negedge clk);
        end
        push = 0;
        feed_done = 1;
    end

    initial
    begin
        pop = 0;
        hold_pop = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (beats_sent > 200 && beats_sent < 260 && !hold_pop)
            begin
                hold_pop = 1;
                pop = 0;
                repeat (400) @(negedge clk);
            end
            if (beats_sent > 1000 && beats_sent < 1200)
                pop = 1;
            else
                pop = ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        wait (feed_done);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

### files.f
design/adsp_pkg.sv
design/adsp_front.sv
design/adsp_queue.sv
design/adsp_back.sv
design/ascii_date_to_packed_stamp.sv
sim/ascii_date_to_packed_stamp_checker.sv
sim/ascii_date_to_packed_stamp_tb.sv
